// ===== sv/ssts_pkg.sv =====
// Package for the subarray target-sum search block.
// Holds the field widths, status codes and sequencer states.
// Has no dependencies; every other file of the block imports it.
`default_nettype none

package ssts_pkg;

	localparam int ELEM_W      = 16;
	localparam int TARGET_W    = 26;
	localparam int RUN_W       = 11;
	localparam int MAX_LEN_DEF = 1024;

	typedef enum logic [1:0] {
		STATUS_FOUND    = 2'd0,
		STATUS_NONE     = 2'd1,
		STATUS_OVERFLOW = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_FINISH
	} state_t;

endpackage

`default_nettype wire

// ===== sv/ssts_elem_if.sv =====
// Valid/ready channel that carries one array element per word.
// Depends on ssts_pkg for the element width.
`default_nettype none

interface ssts_elem_if;
	import ssts_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [ELEM_W-1:0] element_value;
	logic                     is_last;

	modport source (output valid, element_value, is_last, input ready);
	modport sink (input valid, element_value, is_last, output ready);
endinterface

`default_nettype wire

// ===== sv/ssts_res_if.sv =====
// Valid/ready channel that carries one search result per word.
// Depends on ssts_pkg for the status type and index width.
`default_nettype none

interface ssts_res_if;
	import ssts_pkg::*;

	logic             valid;
	logic             ready;
	status_t          status;
	logic [RUN_W-1:0] run_start;
	logic [RUN_W-1:0] run_end;

	modport source (output valid, status, run_start, run_end, input ready);
	modport sink (input valid, status, run_start, run_end, output ready);
endinterface

`default_nettype wire

// ===== sv/subarray_target_sum_search.sv =====
// Subarray target-sum search: an element that arrives when the array is already full is not searched;
// otherwise one compare unit scans the prefix memory one entry per cycle, from entry 0 upward, and the
// scan stops at the first match or when no earlier start is left.
// A result word is registered and the last element may wait in its final cycle for that register.
// Reset clears the target, the sequencer, the array state and the result valid flag; the prefix
// memory needs no clearing. Depends on ssts_pkg, ssts_elem_if and ssts_res_if.
`default_nettype none

module subarray_target_sum_search #(
	parameter int MAX_LEN = ssts_pkg::MAX_LEN_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic signed [ssts_pkg::TARGET_W-1:0] cfg_wdata,
	ssts_elem_if.sink                             elem,
	ssts_res_if.source                            res
);
	import ssts_pkg::*;

	localparam int CNT_W  = $clog2(MAX_LEN + 1);
	localparam int SUM_W  = ELEM_W + CNT_W + 1;
	localparam int WANT_W = ((SUM_W > TARGET_W) ? SUM_W : TARGET_W) + 1;

	state_t state_q, state_d;

	logic signed [TARGET_W-1:0] target_q;
	logic [CNT_W-1:0]           count_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic signed [WANT_W-1:0]   want_q;
	logic [CNT_W-1:0]           best_start_q;
	logic [CNT_W-1:0]           best_end_q;
	logic                       overflow_q;
	logic                       last_q;
	logic                       wr_pend_q;
	logic [CNT_W-1:0]           rd_addr_q;
	logic [CNT_W-1:0]           rd_idx_s1;
	logic                       rd_pend_s1;
	logic signed [SUM_W-1:0]    rd_data_s1;

	logic             res_valid_q;
	status_t          res_status_q;
	logic [RUN_W-1:0] res_start_q;
	logic [RUN_W-1:0] res_end_q;

	logic signed [SUM_W-1:0] prefix_mem [MAX_LEN+1];

	logic                    accept;
	logic                    full;
	logic signed [SUM_W-1:0] new_sum;
	logic signed [WANT_W-1:0] want_d;
	logic                    hit;
	logic                    issue;
	logic                    scan_done;
	logic                    slot_free;
	logic                    emit;
	logic                    mem_we;
	logic [CNT_W-1:0]        mem_waddr;
	logic signed [SUM_W-1:0] mem_wdata;
	logic [CNT_W:0]          next_start;
	logic [CNT_W:0]          hit_start;
	status_t                 status_d;

	assign accept     = elem.valid && elem.ready;
	assign full       = count_q >= CNT_W'(MAX_LEN);
	assign new_sum    = sum_q + SUM_W'(elem.element_value);
	assign want_d     = WANT_W'(new_sum) - WANT_W'(target_q);
	assign hit        = rd_pend_s1 && (WANT_W'(rd_data_s1) == want_q);
	assign scan_done  = !issue && !rd_pend_s1;
	assign slot_free  = !res_valid_q || res.ready;
	assign next_start = {1'b0, rd_addr_q} + 1'b1;
	assign hit_start  = {1'b0, rd_idx_s1} + 1'b1;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = full ? ST_FINISH : ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (hit || scan_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!last_q || slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		elem.ready = 1'b0;
		issue      = 1'b0;
		emit       = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = '0;
		mem_wdata  = '0;
		unique case (state_q)
			ST_IDLE: begin
				elem.ready = 1'b1;
				// Entry 0 is the empty prefix of a new array.
				if (accept && count_q == '0) begin
					mem_we = 1'b1;
				end
			end
			ST_SEARCH: begin
				issue = (rd_addr_q < count_q) && !hit &&
					!(best_start_q != '0 && next_start >= {1'b0, best_start_q});
			end
			ST_FINISH: begin
				mem_we    = wr_pend_q;
				mem_waddr = count_q;
				mem_wdata = sum_q;
				emit      = last_q && slot_free;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		if (overflow_q) begin
			status_d = STATUS_OVERFLOW;
		end else if (best_start_q != '0) begin
			status_d = STATUS_FOUND;
		end else begin
			status_d = STATUS_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			prefix_mem[mem_waddr] <= mem_wdata;
		end
		rd_data_s1 <= prefix_mem[rd_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			target_q     <= '0;
			count_q      <= '0;
			sum_q        <= '0;
			best_start_q <= '0;
			best_end_q   <= '0;
			overflow_q   <= 1'b0;
			last_q       <= 1'b0;
			wr_pend_q    <= 1'b0;
			rd_addr_q    <= '0;
			rd_pend_s1   <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_pend_s1 <= issue;
			if (cfg_we) begin
				target_q <= cfg_wdata;
			end
			if (accept) begin
				last_q    <= elem.is_last;
				wr_pend_q <= !full;
				rd_addr_q <= '0;
				if (full) begin
					overflow_q <= 1'b1;
				end else begin
					sum_q   <= new_sum;
					count_q <= count_q + 1'b1;
				end
			end
			if (issue) begin
				rd_addr_q <= rd_addr_q + 1'b1;
			end
			if (hit && (best_start_q == '0 || hit_start < {1'b0, best_start_q})) begin
				best_start_q <= hit_start[CNT_W-1:0];
				best_end_q   <= count_q;
			end
			if (emit) begin
				res_valid_q  <= 1'b1;
				count_q      <= '0;
				sum_q        <= '0;
				best_start_q <= '0;
				best_end_q   <= '0;
				overflow_q   <= 1'b0;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_addr_q;
		if (accept) begin
			want_q <= want_d;
		end
		if (emit) begin
			res_status_q <= status_d;
			res_start_q  <= (status_d == STATUS_FOUND) ? RUN_W'(best_start_q) : '0;
			res_end_q    <= (status_d == STATUS_FOUND) ? RUN_W'(best_end_q) : '0;
		end
	end

	assign res.valid     = res_valid_q;
	assign res.status    = res_status_q;
	assign res.run_start = res_start_q;
	assign res.run_end   = res_end_q;

endmodule

`default_nettype wire
